FILE: src/odfg_pkg.sv
package odfg_pkg;

	// fixed constants and widths of the datapath
	localparam int PCT = 100;
	localparam int MIN_LIST_RATIO = 6;
	localparam int DIV_W = 23;
	localparam int DEN_W = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;

	// divide by one hundred as (x * 5243) >> 19, exact for x up to 12800
	localparam int PCT_RECIP = 5243;
	localparam int PCT_SHIFT = 19;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_IDLE  = 2'd1,
		OP_APPLY = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		MODE_PERF = 2'd0,
		MODE_SAVE = 2'd1,
		MODE_OD   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_NONE   = 2'd0,
		ST_ACCEPT = 2'd1,
		ST_REJECT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_MODE     = 3'd0,
		REG_MAX      = 3'd1,
		REG_INTERVAL = 3'd2,
		REG_UP       = 3'd3,
		REG_DOWN     = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_TICK,
		CMD_IDLE,
		CMD_CLEAR,
		CMD_REQ
	} cmd_kind_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_EXEC,
		B_DIV1,
		B_CLASS,
		B_DIV2,
		B_REQ,
		B_EMIT
	} back_state_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] timer_now;
	} in_item_t;

	typedef struct packed {
		logic       write_valid;
		logic [7:0] write_ratio;
		logic [1:0] set_status;
		logic [7:0] held_ratio;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  max_ratio;
		logic [15:0] interval;
		logic [6:0]  up;
		logic [6:0]  down;
	} cfg_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  ratio;
		logic [31:0] now;
	} cmd_t;

endpackage

FILE: src/odfg_front.sv
module odfg_front import odfg_pkg::*; (
	input  in_item_t item,
	input  cfg_t     cfg,
	output cmd_t     cmd
);

	// classify one event against the current governor setup
	always_comb begin
		cmd.kind = CMD_NOP;
		cmd.ratio = cfg.max_ratio;
		cmd.now = item.timer_now;
		case (item.opcode)
			OP_TICK: begin
				if (cfg.max_ratio != 8'd0 && cfg.mode == MODE_OD) cmd.kind = CMD_TICK;
			end
			OP_IDLE: begin
				if (cfg.mode == MODE_OD) cmd.kind = CMD_IDLE;
			end
			OP_APPLY: begin
				case (cfg.mode)
					MODE_PERF: begin
						if (cfg.max_ratio != 8'd0) cmd.kind = CMD_REQ;
					end
					MODE_SAVE: begin
						if (cfg.max_ratio != 8'd0) cmd.kind = CMD_REQ;
						cmd.ratio = {1'b0, cfg.max_ratio[7:1]};
					end
					MODE_OD: begin
						cmd.kind = CMD_CLEAR;
					end
					default: begin
						cmd.kind = CMD_NOP;
					end
				endcase
			end
			default: begin
				cmd.kind = CMD_NOP;
			end
		endcase
	end

endmodule

FILE: src/odfg_queue.sv
module odfg_queue import odfg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

FILE: src/odfg_div.sv
module odfg_div import odfg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_W);

	logic [DIV_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// one restoring step per cycle
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff = trial - {1'b0, den_q};
	assign ge = (trial >= {1'b0, den_q});
	assign done = done_q;
	assign quotient = quo_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift registers for remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

endmodule

FILE: src/odfg_back.sv
module odfg_back import odfg_pkg::*; #(
	parameter int LIST_ENTRIES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_valid,
	input  cmd_t      q_head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	back_state_t      state_q, state_d;
	cmd_t             cur_q;
	logic [15:0]      idle_q, total_q, total_next;
	logic [31:0]      last_q;
	logic [7:0]       active_q;
	logic [6:0]       usage_q;
	logic             high_q;
	logic [7:0]       req_q;
	logic             res_wv_q;
	logic [7:0]       res_wr_q;
	logic [1:0]       res_st_q;
	logic             out_valid_q;
	out_item_t        out_q;
	logic             div_start, div_done, out_load;
	logic [DIV_W-1:0] div_quot;
	logic [DIV_W-1:0] prod_idle;
	logic [14:0]      prod_span;
	logic [14:0]      span_prod_q;
	logic [27:0]      recip_prod;
	logic [7:0]       pct_quot;
	logic [7:0]       min_r, span, base, lo, hi;
	logic [8:0]       hi_w, interp;
	logic [7:0]       clamped;
	logic             due, req_ok, go_max, go_min;

	// allowed ratio window
	always_comb begin
		min_r = {1'b0, cfg.max_ratio[7:1]};
		span = cfg.max_ratio - min_r;
		base = (min_r < 8'(MIN_LIST_RATIO)) ? 8'(MIN_LIST_RATIO) : min_r;
		hi_w = {1'b0, base} + 9'(LIST_ENTRIES - 1);
		if (cfg.max_ratio < base) begin
			lo = cfg.max_ratio;
			hi = cfg.max_ratio;
		end else begin
			lo = base;
			hi = (hi_w > {1'b0, cfg.max_ratio}) ? cfg.max_ratio : hi_w[7:0];
		end
	end

	// load decisions
	assign total_next = total_q + 16'd1;
	assign due = ((cur_q.now - last_q) >= {16'd0, cfg.interval});
	assign go_max = high_q || (usage_q > cfg.up);
	assign go_min = (usage_q < cfg.down);
	assign req_ok = (cfg.max_ratio != 8'd0) && (req_q >= lo) && (req_q <= hi)
		&& (req_q != 8'd0);

	// interpolated ratio, span times usage over one hundred
	assign prod_span = span * usage_q;
	assign recip_prod = {13'd0, span_prod_q} * 28'(PCT_RECIP);
	assign pct_quot = recip_prod[PCT_SHIFT +: 8];
	assign interp = {1'b0, min_r} + {1'b0, pct_quot};
	assign clamped = (interp < {1'b0, lo}) ? lo :
		(interp > {1'b0, hi}) ? hi : interp[7:0];

	// idle percentage divider operands
	assign prod_idle = {7'd0, idle_q} * DIV_W'(PCT);

	odfg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_idle),
		.divisor  (total_next),
		.done     (div_done),
		.quotient (div_quot)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= B_IDLE;
		else state_q <= state_d;
	end

	// next state and control
	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		div_start = 1'b0;
		out_load = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					state_d = B_EXEC;
				end
			end
			B_EXEC: begin
				case (cur_q.kind)
					CMD_TICK: begin
						if (!due) state_d = B_EMIT;
						else if (total_next != 16'd0) begin
							div_start = 1'b1;
							state_d = B_DIV1;
						end else state_d = B_CLASS;
					end
					CMD_REQ: state_d = B_REQ;
					default: state_d = B_EMIT;
				endcase
			end
			B_DIV1: begin
				if (div_done) state_d = B_CLASS;
			end
			B_CLASS: begin
				if (go_max || go_min) state_d = B_REQ;
				else state_d = B_DIV2;
			end
			B_DIV2: state_d = B_REQ;
			B_REQ: state_d = B_EMIT;
			B_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// governor counters, active ratio and output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= '0;
			total_q <= '0;
			last_q <= '0;
			active_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == B_EXEC) begin
				case (cur_q.kind)
					CMD_IDLE: idle_q <= idle_q + 16'd1;
					CMD_TICK: total_q <= total_next;
					CMD_CLEAR: begin
						idle_q <= '0;
						total_q <= '0;
						last_q <= cur_q.now;
					end
					default: ;
				endcase
			end
			if (state_q == B_CLASS) begin
				idle_q <= '0;
				total_q <= '0;
				last_q <= cur_q.now;
			end
			if (state_q == B_REQ && req_ok) active_q <= req_q;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_head;
		case (state_q)
			B_EXEC: begin
				res_wv_q <= 1'b0;
				res_wr_q <= '0;
				res_st_q <= ST_NONE;
				usage_q <= '0;
				high_q <= 1'b0;
				req_q <= cur_q.ratio;
			end
			B_DIV1: begin
				if (div_done) begin
					high_q <= (div_quot > DIV_W'(PCT));
					usage_q <= 7'(PCT) - div_quot[6:0];
				end
			end
			B_CLASS: begin
				if (go_max) req_q <= cfg.max_ratio;
				else if (go_min) req_q <= min_r;
				else span_prod_q <= prod_span;
			end
			B_DIV2: begin
				req_q <= clamped;
			end
			B_REQ: begin
				res_wv_q <= req_ok;
				res_wr_q <= req_ok ? req_q : 8'd0;
				res_st_q <= req_ok ? ST_ACCEPT : ST_REJECT;
			end
			default: ;
		endcase
		if (out_load) begin
			out_q.write_valid <= res_wv_q;
			out_q.write_ratio <= res_wr_q;
			out_q.set_status <= res_st_q;
			out_q.held_ratio <= active_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// divider results arrive only while a division is awaited
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == B_DIV1))
		else $error("divider finished outside a division state");

	// a loaded result is presented on the next cycle
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("result beat lost after load");

	// the active ratio moves only on a granted request
	a_active_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(active_q) |-> $past(state_q) == B_REQ)
		else $error("active ratio changed outside request check");

endmodule

FILE: src/ondemand_frequency_governor_top.sv
// Ondemand frequency governor.
// Input channel (in_valid/in_ready/in_data) takes one event per beat: a timer
// tick, an idle mark or an apply-governor request, with the current timer.
// Output channel (out_valid/out_ready/out_data) returns exactly one result per
// event: write flag, ratio written, request status and the active ratio.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the mode,
// max ratio, check interval and the two load thresholds; it is always ready
// and is meant to be written only while no event is in flight.
// Events are decoded on entry and held in a two-entry queue; a back-end
// sequencer executes them one at a time and owns all governor state.
// Per event the sequencer steps as follows: idle marks, plain ticks and clears
// go from execute to emit; apply requests pass the request check first; a
// tick that evaluates load runs the 23-step radix-2 divider for the idle
// percentage (skipped when the tick count wrapped to zero), then classifies
// the load, interpolates with a reciprocal multiply when needed and checks
// the request. It takes the next event only after emitting the last result.
// While the receiver stalls the result holds in the output register, the
// sequencer finishes one more event and the queue keeps taking beats until
// full. Reset clears the counters, the active ratio, the queue and loads the
// default register values.
module ondemand_frequency_governor_top import odfg_pkg::*; #(
	parameter int LIST_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t cfg_q;
	cmd_t in_cmd, q_head;
	logic q_full, q_valid, q_pop;

	assign cfg_ready = 1'b1;
	assign in_ready = !q_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_PERF;
			cfg_q.max_ratio <= 8'd0;
			cfg_q.interval <= 16'd100;
			cfg_q.up <= 7'd80;
			cfg_q.down <= 7'd20;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE: cfg_q.mode <= cfg_data[1:0];
				REG_MAX: cfg_q.max_ratio <= cfg_data[7:0];
				REG_INTERVAL: cfg_q.interval <= cfg_data;
				REG_UP: cfg_q.up <= cfg_data[6:0];
				REG_DOWN: cfg_q.down <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	odfg_front u_front (
		.item (in_data),
		.cfg  (cfg_q),
		.cmd  (in_cmd)
	);

	odfg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !q_full),
		.push_data (in_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	odfg_back #(
		.LIST_ENTRIES (LIST_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: verif/tb_ondemand_frequency_governor_top.sv
module tb_ondemand_frequency_governor_top;
	import odfg_pkg::*;

	localparam int          LIST_ENTRIES = 16;
	localparam logic [1:0]  OP_UNUSED    = 2'd3;
	localparam logic [1:0]  MODE_UNUSED  = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	ondemand_frequency_governor_top #(
		.LIST_ENTRIES(LIST_ENTRIES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// events waiting to be driven and results still owed by the block
	in_item_t  event_q[$];
	out_item_t ratio_result_q[$];

	// run bookkeeping
	int unsigned err_count;
	int unsigned results_seen;
	int unsigned ratio_writes;
	int unsigned rejected_reqs;
	int unsigned reg_writes;
	int unsigned settings_run;
	bit          steady;

	// governor registers and state as the block should hold them
	logic [1:0]  gov_mode;
	logic [7:0]  gov_max;
	logic [15:0] gov_interval;
	logic [6:0]  gov_up;
	logic [6:0]  gov_down;
	logic [15:0] gov_idle;
	logic [15:0] gov_total;
	logic [31:0] gov_last;
	logic [7:0]  gov_ratio;

	// gap length: mostly none, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// allowed ratio window for the current top ratio
	function automatic void ratio_window(output logic [31:0] lo, output logic [31:0] hi);
		logic [31:0] top;
		logic [31:0] base;
		top  = 32'(gov_max);
		base = top / 2;
		if (base < MIN_LIST_RATIO)
			base = MIN_LIST_RATIO;
		if (top < base) begin
			lo = top;
			hi = top;
		end else begin
			lo = base;
			hi = base + LIST_ENTRIES - 1;
			if (hi > top)
				hi = top;
		end
	endfunction

	// ratio request: written only when inside the window
	function automatic void claim_ratio(input logic [31:0] r, inout out_item_t res);
		logic [31:0] lo;
		logic [31:0] hi;
		res.set_status = ST_REJECT;
		if (gov_max != 8'd0) begin
			ratio_window(lo, hi);
			if (r >= lo && r <= hi && r != 0) begin
				res.write_valid = 1'b1;
				res.write_ratio = r[7:0];
				res.set_status  = ST_ACCEPT;
				gov_ratio       = r[7:0];
			end
		end
	endfunction

	// expected result of one event, advancing the governor state
	function automatic out_item_t govern_event(in_item_t ev);
		out_item_t   res;
		logic [31:0] top;
		logic [31:0] half;
		logic [31:0] usage;
		logic [31:0] target;
		logic [31:0] lo;
		logic [31:0] hi;
		res  = '0;
		top  = 32'(gov_max);
		half = top / 2;
		case (ev.opcode)
			OP_TICK: begin
				if (top != 0 && gov_mode == MODE_OD) begin
					gov_total = gov_total + 16'd1;
					if (ev.timer_now - gov_last >= 32'(gov_interval)) begin
						usage = 0;
						// idle above total wraps the percentage to a huge value
						if (gov_total != 0)
							usage = PCT - (32'(gov_idle) * PCT) / 32'(gov_total);
						if (usage > 32'(gov_up)) begin
							claim_ratio(top, res);
						end else if (usage < 32'(gov_down)) begin
							claim_ratio(half, res);
						end else begin
							target = half + ((top - half) * usage) / PCT;
							ratio_window(lo, hi);
							if (target < lo)
								target = lo;
							if (target > hi)
								target = hi;
							claim_ratio(target, res);
						end
						gov_idle  = '0;
						gov_total = '0;
						gov_last  = ev.timer_now;
					end
				end
			end
			OP_IDLE: begin
				if (gov_mode == MODE_OD)
					gov_idle = gov_idle + 16'd1;
			end
			OP_APPLY: begin
				if (gov_mode == MODE_PERF) begin
					if (top != 0)
						claim_ratio(top, res);
				end else if (gov_mode == MODE_SAVE) begin
					if (top != 0)
						claim_ratio(half, res);
				end else if (gov_mode == MODE_OD) begin
					gov_idle  = '0;
					gov_total = '0;
					gov_last  = ev.timer_now;
				end
			end
			default: ;
		endcase
		res.held_ratio = gov_ratio;
		return res;
	endfunction

	// driver: one event beat at a time, random gaps between beats unless steady
	int unsigned in_gap;
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap   <= 0;
		end else begin
			if (in_valid && in_ready)
				ratio_result_q.push_back(govern_event(in_data));
			if (!in_valid || in_ready) begin
				if (in_gap != 0) begin
					in_valid <= 1'b0;
					in_gap   <= in_gap - 1;
				end else if (event_q.size() != 0) begin
					in_valid <= 1'b1;
					in_data  <= event_q.pop_front();
					in_gap   <= steady ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			err_count++;
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endfunction

	// monitor: compare each result beat with the oldest expectation
	int unsigned out_stall;
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (out_data.write_valid)
					ratio_writes++;
				if (out_data.set_status == ST_REJECT)
					rejected_reqs++;
				if (ratio_result_q.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result: expected none, got %h", $time, out_data);
				end else begin
					exp_r = ratio_result_q.pop_front();
					check_field("write_valid", exp_r.write_valid, out_data.write_valid);
					check_field("write_ratio", exp_r.write_ratio, out_data.write_ratio);
					check_field("set_status", exp_r.set_status, out_data.set_status);
					check_field("held_ratio", exp_r.held_ratio, out_data.held_ratio);
				end
			end
			if (out_stall != 0) begin
				out_ready <= 1'b0;
				out_stall <= out_stall - 1;
			end else begin
				out_ready <= 1'b1;
				out_stall <= steady ? 0 : pick_gap();
			end
		end
	end

	task automatic push_event(logic [1:0] op, logic [31:0] t);
		in_item_t ev;
		ev.opcode    = op;
		ev.timer_now = t;
		event_q.push_back(ev);
	endtask

	// wait until every queued event has produced its result
	task automatic drain_results();
		while (event_q.size() != 0 || in_valid || ratio_result_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			REG_MODE:     gov_mode     = val[1:0];
			REG_MAX:      gov_max      = val[7:0];
			REG_INTERVAL: gov_interval = val;
			REG_UP:       gov_up       = val[6:0];
			REG_DOWN:     gov_down     = val[6:0];
			default: ;
		endcase
	endtask

	// new register setting, applied only once the block has gone quiet
	task automatic set_regs(logic [1:0] mode, logic [7:0] top, logic [15:0] intv,
			logic [6:0] up, logic [6:0] down);
		drain_results();
		write_reg(REG_MODE, 16'(mode));
		write_reg(REG_MAX, 16'(top));
		write_reg(REG_INTERVAL, intv);
		write_reg(REG_UP, 16'(up));
		write_reg(REG_DOWN, 16'(down));
		settings_run++;
	endtask

	function automatic logic [7:0] pick_max();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 8'd0;
		else if (r < 10)
			return 8'd255;
		else if (r < 30)
			return 8'($urandom_range(1, 12));
		else if (r < 75)
			return 8'($urandom_range(13, 60));
		return 8'($urandom_range(61, 255));
	endfunction

	function automatic logic [15:0] pick_interval();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 16'($urandom_range(0, 20));
		else if (r < 90)
			return 16'($urandom_range(21, 200));
		else if (r < 95)
			return 16'hffff;
		return 16'($urandom);
	endfunction

	// ondemand traffic: clear, ticks, idle marks at a drifting share, some noise
	task automatic queue_ondemand_load(int unsigned n_items);
		logic [31:0] t;
		int unsigned idle_pct;
		int unsigned left_in_window;
		int unsigned sent;
		t              = $urandom;
		idle_pct       = 0;
		left_in_window = 0;
		sent           = 1;
		push_event(OP_APPLY, t);
		while (sent < n_items) begin
			if (left_in_window == 0) begin
				idle_pct       = $urandom_range(0, 60);
				left_in_window = $urandom_range(1, 12);
				if ($urandom_range(0, 99) < 5) begin
					push_event(OP_APPLY, t);
					sent++;
				end
			end
			left_in_window--;
			if ($urandom_range(0, 99) < 8) begin
				// noise: any opcode at any time stamp
				push_event(2'($urandom_range(0, 3)), $urandom);
				sent++;
			end
			repeat (2) begin
				if ($urandom_range(0, 99) < idle_pct) begin
					push_event(OP_IDLE, $urandom);
					sent++;
				end
			end
			if ($urandom_range(0, 99) < 3)
				t = t + $urandom_range(0, 500);
			else
				t = t + $urandom_range(0, 3);
			push_event(OP_TICK, t);
			sent++;
		end
	endtask

	task automatic queue_mixed_events(int unsigned n_items);
		repeat (n_items)
			push_event(2'($urandom_range(0, 3)), $urandom);
	endtask

	// stimulus and end of run
	initial begin
		logic [1:0] mode;
		int unsigned r;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_gap    = 0;
		out_stall = 0;
		steady    = 1'b0;
		err_count = 0;
		results_seen  = 0;
		ratio_writes  = 0;
		rejected_reqs = 0;
		reg_writes    = 0;
		settings_run  = 0;
		gov_mode     = MODE_PERF;
		gov_max      = 8'd0;
		gov_interval = 16'd100;
		gov_up       = 7'd80;
		gov_down     = 7'd20;
		gov_idle     = '0;
		gov_total    = '0;
		gov_last     = '0;
		gov_ratio    = '0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: scaling unavailable, nothing gets requested
		push_event(OP_APPLY, 32'd0);
		push_event(OP_TICK, 32'hffff_ffff);
		push_event(OP_IDLE, 32'd0);
		push_event(OP_UNUSED, 32'hffff_ffff);

		// fixed governors: top ratio outside the window, then half accepted
		set_regs(MODE_PERF, 8'd255, 16'd100, 7'd80, 7'd20);
		push_event(OP_APPLY, 32'd7);
		set_regs(MODE_SAVE, 8'd255, 16'd100, 7'd80, 7'd20);
		push_event(OP_APPLY, 32'd7);
		set_regs(MODE_PERF, 8'd20, 16'd100, 7'd80, 7'd20);
		push_event(OP_APPLY, 32'd7);
		// half below the list floor of six
		set_regs(MODE_SAVE, 8'd8, 16'd100, 7'd80, 7'd20);
		push_event(OP_APPLY, 32'd7);
		// top below the floor: single-entry list
		set_regs(MODE_PERF, 8'd5, 16'd100, 7'd80, 7'd20);
		push_event(OP_APPLY, 32'd7);
		set_regs(MODE_SAVE, 8'd5, 16'd100, 7'd80, 7'd20);
		push_event(OP_APPLY, 32'd7);
		// half of one is a zero ratio
		set_regs(MODE_SAVE, 8'd1, 16'd100, 7'd80, 7'd20);
		push_event(OP_APPLY, 32'd7);

		// zero interval: every tick evaluates; idle above total counts as busy
		set_regs(MODE_OD, 8'd40, 16'd0, 7'd80, 7'd20);
		push_event(OP_APPLY, 32'd1000);
		push_event(OP_IDLE, 32'd0);
		push_event(OP_IDLE, 32'd0);
		push_event(OP_TICK, 32'd1000);
		push_event(OP_TICK, 32'd1000);
		push_event(OP_IDLE, 32'd0);
		push_event(OP_TICK, 32'd1000);

		// medium load interpolation
		set_regs(MODE_OD, 8'd30, 16'd0, 7'd100, 7'd0);
		push_event(OP_TICK, 32'd5);
		push_event(OP_IDLE, 32'd5);
		push_event(OP_TICK, 32'd5);
		set_regs(MODE_OD, 8'd30, 16'd2, 7'd100, 7'd0);
		push_event(OP_APPLY, 32'd0);
		push_event(OP_IDLE, 32'd0);
		push_event(OP_TICK, 32'd1);
		push_event(OP_TICK, 32'd2);

		// unused governor mode
		set_regs(MODE_UNUSED, 8'd30, 16'd0, 7'd80, 7'd20);
		push_event(OP_APPLY, 32'd9);
		push_event(OP_TICK, 32'd9);
		push_event(OP_IDLE, 32'd9);

		// widest interval, extreme thresholds, timer wrapping past zero
		set_regs(MODE_OD, 8'd255, 16'hffff, 7'd0, 7'd100);
		push_event(OP_APPLY, 32'hffff_0000);
		push_event(OP_TICK, 32'hffff_ffff);
		push_event(OP_IDLE, 32'd0);
		push_event(OP_TICK, 32'd0);

		// random register settings with traffic shaped to each mode
		repeat (12) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				mode = MODE_PERF;
			else if (r == 1)
				mode = MODE_SAVE;
			else if (r == 2)
				mode = MODE_UNUSED;
			else
				mode = MODE_OD;
			set_regs(mode, pick_max(), pick_interval(), 7'($urandom_range(0, 100)),
				7'($urandom_range(0, 100)));
			steady = ($urandom_range(0, 3) == 0);
			if (mode == MODE_OD)
				queue_ondemand_load(100);
			else
				queue_mixed_events(100);
		end

		drain_results();
		repeat (60) @(posedge clk);
		$display("checked %0d results over %0d register settings (%0d register writes)",
			results_seen, settings_run, reg_writes);
		$display("ratio writes %0d, rejected requests %0d", ratio_writes, rejected_reqs);
		if (err_count == 0)
			$display("tb_ondemand_frequency_governor_top OK");
		else
			$display("tb_ondemand_frequency_governor_top NOT OK");
		$finish;
	end

	// run limit
	initial begin
		#30_000_000;
		$display("timeout: %0d results still owed", ratio_result_q.size());
		$display("tb_ondemand_frequency_governor_top NOT OK");
		$finish;
	end

endmodule

FILE: filelist.f
src/odfg_pkg.sv
src/odfg_front.sv
src/odfg_queue.sv
src/odfg_div.sv
src/odfg_back.sv
src/ondemand_frequency_governor_top.sv
verif/tb_ondemand_frequency_governor_top.sv
